/* sv/rau_pkg.sv */
`timescale 1ns / 1ps
// Package for the rational arithmetic unit: operation codes, status codes,
// field widths and defaults. No dependencies.
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int CMD_W         = 3;
  localparam int NUM_W         = 33;
  localparam int DEN_W         = 32;
  localparam int STATUS_W      = 2;

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd4;

  localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STS_ZERO_DEN = 2'd1;
  localparam logic [STATUS_W-1:0] STS_DIV_ZERO = 2'd2;

endpackage

/* sv/rational_arithmetic_unit.sv */
`timescale 1ns / 1ps
// Rational arithmetic unit top level: sequencer, shared multiplier, gcd loop.
// Depends on rau_pkg and rau_div.
//
// Takes one word holding an operation (add, subtract, multiply, divide) and two
// signed fractions, forms the raw cross products, then reduces the result by a
// Euclidean gcd with truncating remainder, so the sign of the result denominator
// follows C semantics. A zero input denominator gives status 1, a zero divisor
// numerator on divide gives status 2, and an unknown operation gives status 0;
// all three return 0/1. One word is in flight at a time: tready is high only
// while the sequencer is idle. The shared divider, one quotient bit per cycle,
// computes every Euclid remainder and both final quotients on 2*OPERAND_WIDTH
// (32 by default) bit magnitudes. An error word goes from idle straight to the
// output state. The result sits in an output register, so a new word is taken
// while it waits.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // cmd, x_num, x_den, y_num, y_den, zero fill
  input  logic [((rau_pkg::CMD_W + 4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // res_num, res_den, zero fill
  output logic [((rau_pkg::NUM_W + rau_pkg::DEN_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // status
  output logic [rau_pkg::STATUS_W-1:0] m_axis_tuser
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W;
  localparam int XW = (MW > rau_pkg::NUM_W) ? MW : rau_pkg::NUM_W;
  localparam int OW = ((rau_pkg::NUM_W + rau_pkg::DEN_W + 7) / 8) * 8;
  localparam int CW = rau_pkg::CMD_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MA   = 4'd1;
  localparam logic [3:0] ST_MB   = 4'd2;
  localparam logic [3:0] ST_MC   = 4'd3;
  localparam logic [3:0] ST_SUM  = 4'd4;
  localparam logic [3:0] ST_GCD  = 4'd5;
  localparam logic [3:0] ST_DN   = 4'd6;
  localparam logic [3:0] ST_DD   = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0] state;

  logic [CW-1:0] cmd;
  logic [W-1:0]  xn_mag, xd_mag, yn_mag, yd_mag;
  logic          xn_neg, xd_neg, yn_neg, yd_neg;

  logic [MW-1:0] numa_mag, numb_mag, den_mag, num_mag;
  logic          numa_neg, numb_neg, den_neg, num_neg, g_neg, idx_odd;
  logic [MW-1:0] prev, cur, rn_mag, rd_mag;
  logic [rau_pkg::STATUS_W-1:0] status;
  logic          div_start;

  logic [CW-1:0] in_cmd;
  logic [W-1:0]  in_xn, in_xd, in_yn, in_yd;

  logic [W-1:0]  mul_a, mul_b;
  logic          mul_sign;
  logic [MW-1:0] prod;
  logic          prod_neg;

  logic [MW-1:0] sum_mag;
  logic          sum_neg;

  logic          div_done;
  logic [MW-1:0] div_q, div_r;

  logic [XW-1:0] rn_ext, rd_ext, rn_enc, rd_enc;
  logic          rn_neg, rd_neg;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  assign in_cmd = s_axis_tdata[CW-1:0];
  assign in_xn  = s_axis_tdata[CW +: W];
  assign in_xd  = s_axis_tdata[CW + W +: W];
  assign in_yn  = s_axis_tdata[CW + 2 * W +: W];
  assign in_yd  = s_axis_tdata[CW + 3 * W +: W];

  assign s_axis_tready = (state == ST_IDLE);

  // shared multiplier operand select
  always_comb begin
    mul_a    = xd_mag;
    mul_b    = yd_mag;
    mul_sign = xd_neg ^ yd_neg;
    case (state)
      ST_MA: begin
        mul_a = xn_mag;
        if (cmd == rau_pkg::CMD_MUL) begin
          mul_b    = yn_mag;
          mul_sign = xn_neg ^ yn_neg;
        end else begin
          mul_b    = yd_mag;
          mul_sign = xn_neg ^ yd_neg;
        end
      end
      ST_MB: begin
        mul_a    = yn_mag;
        mul_b    = xd_mag;
        mul_sign = (yn_neg ^ xd_neg) ^ (cmd == rau_pkg::CMD_SUB);
      end
      ST_MC: begin
        mul_a = xd_mag;
        if (cmd == rau_pkg::CMD_DIV) begin
          mul_b    = yn_mag;
          mul_sign = xd_neg ^ yn_neg;
        end else begin
          mul_b    = yd_mag;
          mul_sign = xd_neg ^ yd_neg;
        end
      end
      default: begin
        mul_a = xd_mag;
      end
    endcase
    prod     = MW'(mul_a) * MW'(mul_b);
    prod_neg = mul_sign && (prod != '0);
  end

  // signed-magnitude add of the two cross products
  always_comb begin
    if (numa_neg == numb_neg) begin
      sum_mag = numa_mag + numb_mag;
      sum_neg = numa_neg;
    end else if (numa_mag >= numb_mag) begin
      sum_mag = numa_mag - numb_mag;
      sum_neg = numa_neg;
    end else begin
      sum_mag = numb_mag - numa_mag;
      sum_neg = numb_neg;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  rau_div #(
    .WIDTH (MW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (prev),
    .divisor   (cur),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    rn_neg = (num_neg != g_neg) && (rn_mag != '0);
    rd_neg = (den_neg != g_neg) && (rd_mag != '0);
    rn_ext = XW'(rn_mag);
    rd_ext = XW'(rd_mag);
    rn_enc = rn_neg ? (~rn_ext + XW'(1)) : rn_ext;
    rd_enc = rd_neg ? (~rd_ext + XW'(1)) : rd_ext;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (in_cmd < rau_pkg::CMD_ADD || in_cmd > rau_pkg::CMD_DIV) begin
              state <= ST_OUT;
            end else if (in_xd == '0 || in_yd == '0) begin
              state <= ST_OUT;
            end else if (in_cmd == rau_pkg::CMD_DIV && in_yn == '0) begin
              state <= ST_OUT;
            end else begin
              state <= ST_MA;
            end
          end
        end
        ST_MA: begin
          if (cmd == rau_pkg::CMD_ADD || cmd == rau_pkg::CMD_SUB) begin
            state <= ST_MB;
          end else begin
            state <= ST_MC;
          end
        end
        ST_MB: state <= ST_MC;
        ST_MC: state <= ST_SUM;
        ST_SUM: begin
          div_start <= 1'b1;
          state     <= ST_GCD;
        end
        ST_GCD: begin
          if (div_done) begin
            div_start <= 1'b1;
            state     <= (div_r == '0) ? ST_DN : ST_GCD;
          end
        end
        ST_DN: begin
          if (div_done) begin
            div_start <= 1'b1;
            state     <= ST_DD;
          end
        end
        ST_DD: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd     <= in_cmd;
        xn_mag  <= mag_of(in_xn);
        xd_mag  <= mag_of(in_xd);
        yn_mag  <= mag_of(in_yn);
        yd_mag  <= mag_of(in_yd);
        xn_neg  <= in_xn[W-1];
        xd_neg  <= in_xd[W-1];
        yn_neg  <= in_yn[W-1];
        yd_neg  <= in_yd[W-1];
        rn_mag  <= '0;
        rd_mag  <= MW'(1);
        num_neg <= 1'b0;
        den_neg <= 1'b0;
        g_neg   <= 1'b0;
        if (in_cmd < rau_pkg::CMD_ADD || in_cmd > rau_pkg::CMD_DIV) begin
          status <= rau_pkg::STS_OK;
        end else if (in_xd == '0 || in_yd == '0) begin
          status <= rau_pkg::STS_ZERO_DEN;
        end else if (in_cmd == rau_pkg::CMD_DIV && in_yn == '0) begin
          status <= rau_pkg::STS_DIV_ZERO;
        end else begin
          status <= rau_pkg::STS_OK;
        end
      end
      ST_MA: begin
        numa_mag <= prod;
        numa_neg <= prod_neg;
        numb_mag <= '0;
        numb_neg <= 1'b0;
      end
      ST_MB: begin
        numb_mag <= prod;
        numb_neg <= prod_neg;
      end
      ST_MC: begin
        den_mag <= prod;
        den_neg <= prod_neg;
      end
      ST_SUM: begin
        num_mag <= sum_mag;
        num_neg <= sum_neg;
        prev    <= sum_mag;
        cur     <= den_mag;
        idx_odd <= 1'b1;
      end
      ST_GCD: begin
        if (div_done) begin
          if (div_r == '0) begin
            g_neg <= idx_odd ? den_neg : num_neg;
            prev  <= num_mag;
          end else begin
            prev    <= cur;
            cur     <= div_r;
            idx_odd <= !idx_odd;
          end
        end
      end
      ST_DN: begin
        if (div_done) begin
          rn_mag <= div_q;
          prev   <= den_mag;
        end
      end
      ST_DD: begin
        if (div_done) begin
          rd_mag <= div_q;
        end
      end
      default: begin
        prev <= prev;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= OW'({rd_enc[rau_pkg::DEN_W-1:0], rn_enc[rau_pkg::NUM_W-1:0]});
      m_axis_tuser <= status;
    end
  end

endmodule

/* sv/rau_div.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider for the rational arithmetic unit, one quotient
// bit per cycle. Standalone; no package dependencies.
module rau_div #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             qbit;

  always_comb begin
    trial = {rem, quo[WIDTH-1]};
    diff  = trial - {1'b0, dvs};
    qbit  = !diff[WIDTH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CW'(WIDTH);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - CW'(1);
      done <= (cnt == CW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo <= {quo[WIDTH-2:0], qbit};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for rational_arithmetic_unit: directed and random fraction words,
// each checked against an in-bench sign-magnitude predictor with Euclid reduction.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
module tb_top;
  import rau_pkg::*;

  localparam int IN_W         = ((CMD_W + 4 * OPERAND_WIDTH + 7) / 8) * 8;
  localparam int OUT_W        = ((NUM_W + DEN_W + 7) / 8) * 8;
  localparam int RANDOM_WORDS = 1000;
  localparam int PHASE_WORDS  = 342;
  localparam int TAIL_CYCLES  = 2000;
  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int REPORT_MAX   = 10;
  localparam logic [CMD_W-1:0] CMD_NOP = 3'd0;

  typedef logic signed [OPERAND_WIDTH-1:0] operand_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    operand_t         xn;
    operand_t         xd;
    operand_t         yn;
    operand_t         yd;
    bit               drain;
  } fraction_op_t;

  typedef struct packed {
    logic [NUM_W-1:0]    num;
    logic [DEN_W-1:0]    den;
    logic [STATUS_W-1:0] status;
  } ratio_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } sm_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  fraction_op_t pending_ops[$];
  ratio_t       expected_ratios[$];
  int           words_sent = 0;
  int           words_received = 0;
  int           error_count = 0;
  int           total_words = 0;
  int           cycle_count = 0;

  rational_arithmetic_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sm_t to_sm(operand_t v);
    sm_t         r;
    logic [63:0] u;
    u = '0;
    u[OPERAND_WIDTH-1:0] = v;
    r.neg = v[OPERAND_WIDTH-1];
    r.mag = r.neg ? ((64'd1 << OPERAND_WIDTH) - u) : u;
    return r;
  endfunction

  function automatic sm_t sm_mul(sm_t a, sm_t b);
    sm_t r;
    r.mag = a.mag * b.mag;
    r.neg = (a.neg != b.neg) && (r.mag != 0);
    return r;
  endfunction

  function automatic sm_t sm_add(sm_t a, sm_t b);
    sm_t r;
    if (a.neg == b.neg) begin
      r.neg = a.neg;
      r.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg;
      r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg;
      r.mag = b.mag - a.mag;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  // cross products, then divide by the truncating-remainder Euclid gcd
  function automatic ratio_t reduce_ratio(fraction_op_t w);
    ratio_t      r;
    sm_t         xn, xd, yn, yd, num, den, t, g, rn, rd;
    logic [63:0] prev, cur, rem, enc;
    int unsigned steps;
    r.num = '0;
    r.den = 1;
    r.status = STS_OK;
    if (w.cmd != CMD_ADD && w.cmd != CMD_SUB && w.cmd != CMD_MUL && w.cmd != CMD_DIV)
      return r;
    if (w.xd == 0 || w.yd == 0) begin
      r.status = STS_ZERO_DEN;
      return r;
    end
    if (w.cmd == CMD_DIV && w.yn == 0) begin
      r.status = STS_DIV_ZERO;
      return r;
    end
    xn = to_sm(w.xn);
    xd = to_sm(w.xd);
    yn = to_sm(w.yn);
    yd = to_sm(w.yd);
    if (w.cmd == CMD_ADD || w.cmd == CMD_SUB) begin
      t = sm_mul(yn, xd);
      if (w.cmd == CMD_SUB && t.mag != 0) t.neg = !t.neg;
      num = sm_add(sm_mul(xn, yd), t);
      den = sm_mul(xd, yd);
    end else if (w.cmd == CMD_MUL) begin
      num = sm_mul(xn, yn);
      den = sm_mul(xd, yd);
    end else begin
      num = sm_mul(xn, yd);
      den = sm_mul(xd, yn);
    end
    // odd step count: gcd sign from the denominator, even: from the numerator
    prev = num.mag;
    cur = den.mag;
    steps = 1;
    rem = prev % cur;
    while (rem != 0) begin
      prev = cur;
      cur = rem;
      steps++;
      rem = prev % cur;
    end
    g.mag = cur;
    g.neg = steps[0] ? den.neg : num.neg;
    rn.mag = num.mag / g.mag;
    rn.neg = (num.neg != g.neg) && (rn.mag != 0);
    rd.mag = den.mag / g.mag;
    rd.neg = (den.neg != g.neg) && (rd.mag != 0);
    enc = rn.neg ? (64'd0 - rn.mag) : rn.mag;
    r.num = enc[NUM_W-1:0];
    enc = rd.neg ? (64'd0 - rd.mag) : rd.mag;
    r.den = enc[DEN_W-1:0];
    return r;
  endfunction

  function automatic operand_t rand_operand(bit nonzero);
    operand_t    v;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      v = operand_t'($urandom);
    end else if (pick < 75) begin
      v = operand_t'(int'($urandom_range(40)) - 20);
    end else if (pick < 90) begin
      case ($urandom_range(3))
        0: v = 16'sh8000;
        1: v = 16'sh7fff;
        2: v = -16'sd1;
        default: v = 16'sd1;
      endcase
    end else begin
      v = operand_t'(1 << $urandom_range(OPERAND_WIDTH - 1));
      if ($urandom_range(1)) v = -v;
    end
    while (nonzero && v == 0) v = operand_t'($urandom);
    return v;
  endfunction

  // phase 0: sender 37 / receiver 51, phase 1: swapped, then no idling
  function automatic int idle_pct(int count, bit receiver);
    if (count < PHASE_WORDS) return receiver ? 51 : 37;
    if (count < 2 * PHASE_WORDS) return receiver ? 37 : 51;
    return 0;
  endfunction

  task automatic add_word(logic [CMD_W-1:0] cmd, operand_t xn, operand_t xd,
                          operand_t yn, operand_t yd);
    fraction_op_t w;
    w.cmd = cmd;
    w.xn = xn;
    w.xd = xd;
    w.yn = yn;
    w.yd = yd;
    w.drain = 1'b0;
    pending_ops.push_back(w);
  endtask

  always @(posedge clk) begin : sender
    bit           taken;
    fraction_op_t w;
    taken = s_axis_tvalid && s_axis_tready;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (taken) begin
        expected_ratios.push_back(reduce_ratio(pending_ops.pop_front()));
        words_sent++;
      end
      if (s_axis_tvalid && !taken) begin
        // word still offered, hold it
      end else if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct(words_sent, 1'b0)
                   && (!pending_ops[0].drain || expected_ratios.size() == 0)) begin
        w = pending_ops[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_W - CMD_W - 4 * OPERAND_WIDTH){1'b0}},
                         w.yd, w.yn, w.xd, w.xn, w.cmd};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : receiver
    ratio_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.num = m_axis_tdata[NUM_W-1:0];
        got.den = m_axis_tdata[NUM_W+DEN_W-1:NUM_W];
        got.status = m_axis_tuser;
        words_received++;
        if (expected_ratios.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("unexpected result word: num=%0d den=%0d status=%0d",
                     $signed(got.num), $signed(got.den), got.status);
        end else begin
          want = expected_ratios.pop_front();
          if (got.num !== want.num || got.den !== want.den || got.status !== want.status) begin
            error_count++;
            if (error_count <= REPORT_MAX)
              $display("result word %0d: expected %0d/%0d status %0d, got %0d/%0d status %0d",
                       words_received - 1, $signed(want.num), $signed(want.den), want.status,
                       $signed(got.num), $signed(got.den), got.status);
          end
        end
      end
      m_axis_tready <= $urandom_range(99) >= idle_pct(words_received, 1'b1);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rational_arithmetic_unit: mismatch");
      $finish;
    end
  end

  initial begin
    fraction_op_t w;
    int unsigned  pick;
    // directed words
    add_word(CMD_ADD, 1, 2, 1, 3);
    add_word(CMD_SUB, 1, 2, 1, 2);
    add_word(CMD_MUL, -32768, 32767, 32767, -32768);
    add_word(CMD_DIV, -32768, -32768, -32768, -32768);
    add_word(CMD_ADD, 32767, 1, 32767, 1);
    add_word(CMD_SUB, -32768, 1, 32767, 1);
    add_word(CMD_ADD, -32768, -32768, -32768, -32768);
    add_word(CMD_MUL, 0, 5, 3, -7);
    add_word(CMD_DIV, 3, 4, 0, 5);
    add_word(CMD_ADD, 1, 0, 1, 1);
    add_word(CMD_DIV, 1, 1, 0, 0);
    add_word(CMD_MUL, 1, 1, 1, 0);
    add_word(CMD_NOP, 5, 3, 2, 7);
    add_word(CMD_DIV + 3'd3, -1, -1, -1, -1);
    add_word(CMD_DIV + 3'd1, 4, 0, 0, 0);
    add_word(CMD_DIV, -1, -1, -1, -1);
    add_word(CMD_SUB, 5, -6, 7, -10);
    add_word(CMD_MUL, 6, -4, -2, 3);
    add_word(CMD_DIV, 32767, -1, -32768, 1);
    add_word(CMD_ADD, -1, 32767, 1, -32768);
    add_word(CMD_DIV + 3'd2, 0, 1, 0, 1);
    add_word(CMD_DIV, 0, 3, 5, 7);
    add_word(CMD_SUB, 32767, -32768, -32768, 32767);
    // random words
    repeat (RANDOM_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 5) w.cmd = CMD_DIV + CMD_W'($urandom_range(1, 4));
      else w.cmd = CMD_ADD + CMD_W'($urandom_range(3));
      w.xn = rand_operand(1'b0);
      w.xd = rand_operand($urandom_range(99) >= 3);
      w.yn = rand_operand(1'b0);
      w.yd = rand_operand($urandom_range(99) >= 3);
      w.drain = 1'b0;
      pending_ops.push_back(w);
    end
    // sender waits for the pipe to empty at these points
    pending_ops[23].drain = 1'b1;
    pending_ops[PHASE_WORDS].drain = 1'b1;
    pending_ops[2 * PHASE_WORDS].drain = 1'b1;
    total_words = pending_ops.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (words_sent != total_words || expected_ratios.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("rational_arithmetic_unit: match");
    end else begin
      $display("rational_arithmetic_unit: mismatch");
    end
    $finish;
  end

endmodule
